>>> src/led_scanner_pattern_generator_assert.svh
// Assertion macros for the LED scanner pattern generator.
// Every macro expects signals named clk and rst_n in the including scope.
`ifndef LED_SCANNER_PATTERN_GENERATOR_ASSERT_SVH
`define LED_SCANNER_PATTERN_GENERATOR_ASSERT_SVH

// The condition implies the consequence in the same cycle.
`define LSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition implies the consequence in the next cycle.
`define LSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lsp_pkg.sv
// Shared types, constants and pattern helpers for the LED scanner pattern generator.
// No dependencies.
`timescale 1ns / 1ps

package lsp_pkg;

    localparam int LED_COUNT   = 8;
    localparam int CYCLE_TICKS = 20;

    localparam logic [31:0] LFSR_TAPS  = 32'hD000_0001;
    localparam logic [31:0] SEED_RESET = 32'd12345;
    localparam logic [8:0]  HOLD_BASE  = 9'd50;
    localparam logic [8:0]  HOLD_STEP  = 9'd50;

    // Effect codes from the switches
    typedef enum logic [2:0] {
        FX_SCANNER     = 3'd0,
        FX_CENTER      = 3'd1,
        FX_PAIR        = 3'd2,
        FX_CHASE_LEFT  = 3'd3,
        FX_CHASE_RIGHT = 3'd4,
        FX_EXPAND      = 3'd5,
        FX_SPARKLE     = 3'd6,
        FX_CYCLE       = 3'd7
    } effect_t;

    // Auto-cycle sub-effect codes
    localparam logic [2:0] SUB_SCANNER2 = 3'd0;
    localparam logic [2:0] SUB_CENTER3  = 3'd1;
    localparam logic [2:0] SUB_PAIR     = 3'd2;
    localparam logic [2:0] SUB_SINGLE   = 3'd3;
    localparam logic [2:0] SUB_DOUBLE   = 3'd4;
    localparam logic [2:0] SUB_FILL     = 3'd5;
    localparam logic [2:0] SUB_LAST     = SUB_FILL;

    typedef struct packed {
        logic [2:0] speed;
        logic [1:0] width;
        logic [2:0] effect;
    } tick_t;

    typedef struct packed {
        logic [31:0] rnd;
        logic [4:0]  tick_cnt;
        logic [2:0]  sub;
        logic        expanding;
        logic        moving_left;
        logic [2:0]  pos;
    } scan_state_t;

    // One-hot LED bit, zero when off the strip
    function automatic logic [7:0] bit_at(input logic signed [4:0] n);
        logic [7:0] b;
        b = '0;
        if (n >= 5'sd0 && n <= 5'sd7)
        begin
            b = 8'd1 << n[2:0];
        end
        return b;
    endfunction

    function automatic logic [7:0] center_bits(input logic [2:0] pos, input logic [2:0] w);
        logic [7:0] p;
        p = 8'd1 << pos;
        if (w > 3'd1 && pos > 3'd0)
        begin
            p = p | (8'd1 << (pos - 3'd1));
        end
        if (w > 3'd2 && pos < 3'd7)
        begin
            p = p | (8'd1 << (pos + 3'd1));
        end
        return p;
    endfunction

    function automatic logic [7:0] pair_bits(input logic [2:0] pos);
        return (8'd1 << pos) | (8'd1 << (3'd7 - pos));
    endfunction

endpackage

>>> src/led_scanner_pattern_generator.sv
// LED scanner pattern generator, top level. An accepted tick request reaches
// its result through the input register, then the result register.
// Throughput: one tick request per cycle unless the result side stalls; the scan
// state loop (lsp_state -> lsp_pattern -> lsp_state) holds a single register.
// Reset (rst_n, async, active low): no items held, position 0 moving right,
// expand flag set, auto-cycle at sub-effect 0, LFSR loaded with 12345.
`timescale 1ns / 1ps
`include "led_scanner_pattern_generator_assert.svh"

module led_scanner_pattern_generator (
    input  logic        clk,
    input  logic        rst_n,
    // tick requests
    input  logic        tick_valid,
    output logic        tick_stall,
    input  logic [2:0]  speed_code,
    input  logic [1:0]  width_code,
    input  logic [2:0]  effect_select,
    // seed register
    input  logic        random_seed_we,
    input  logic [31:0] random_seed,
    // results
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  led_pattern,
    output logic [8:0]  hold_ms
);

    // Input register: holds one tick request until the result stage frees up.
    logic           tick_valid_reg;
    logic           tick_valid_next;
    lsp_pkg::tick_t tick_reg;

    // Result register
    logic           result_valid_reg;
    logic           result_valid_next;
    logic [7:0]     led_pattern_reg;
    logic [8:0]     hold_ms_reg;

    logic                 result_free;  // result stage can take a new request
    logic                 advance;      // input register moves to result register
    logic                 accept;
    logic [7:0]           pattern;
    logic [8:0]           hold;
    lsp_pkg::scan_state_t cur_state;
    lsp_pkg::scan_state_t nxt_state;

    assign result_free = ~result_valid_reg | ~result_stall;
    assign advance     = tick_valid_reg & result_free;
    assign tick_stall  = tick_valid_reg & ~result_free;
    assign accept      = tick_valid & ~tick_stall;

    // Pattern logic works on the request in the input register against the
    // current scan state; the state commits only when the request advances.
    lsp_pattern u_pattern (
        .tick    (tick_reg),
        .cur     (cur_state),
        .pattern (pattern),
        .hold    (hold),
        .nxt     (nxt_state)
    );

    lsp_state u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .seed_we  (random_seed_we),
        .seed     (random_seed),
        .update   (advance),
        .state_in (nxt_state),
        .state    (cur_state)
    );

    always_comb
    begin
        tick_valid_next = tick_valid_reg;
        if (accept)
        begin
            tick_valid_next = 1'b1;
        end
        else if (advance)
        begin
            tick_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            tick_valid_reg   <= tick_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tick_reg.speed  <= speed_code;
            tick_reg.width  <= width_code;
            tick_reg.effect <= effect_select;
        end
        if (advance)
        begin
            led_pattern_reg <= pattern;
            hold_ms_reg     <= hold;
        end
    end

    assign result_valid = result_valid_reg;
    assign led_pattern  = led_pattern_reg;
    assign hold_ms      = hold_ms_reg;

    // A held request is never dropped while the result side is blocked.
    `LSP_ASSERT_NEXT(a_hold_request, tick_valid_reg && result_valid_reg && result_stall, tick_valid_reg, "request lost while result stalled")
    // A request that advances shows up as a result next cycle.
    `LSP_ASSERT_NEXT(a_request_to_result, advance, result_valid_reg && hold_ms_reg == $past(hold), "advanced request missing from result")
    // Auto-cycle counters stay in their ranges.
    `LSP_ASSERT_NOW(a_cycle_range, 1'b1, cur_state.tick_cnt <= 5'(lsp_pkg::CYCLE_TICKS) && cur_state.sub <= lsp_pkg::SUB_LAST, "auto-cycle state out of range")
    // Hold time of a shown result is within 50..400 ms.
    `LSP_ASSERT_NOW(a_hold_range, result_valid_reg, hold_ms_reg >= 9'd50 && hold_ms_reg <= 9'd400, "hold time out of range")

endmodule

>>> src/lsp_pattern.sv
// Pattern and next-state logic for one tick (pure combinational).
// Depends on lsp_pkg.
`timescale 1ns / 1ps

module lsp_pattern (
    input  lsp_pkg::tick_t       tick,
    input  lsp_pkg::scan_state_t cur,
    output logic [7:0]           pattern,
    output logic [8:0]           hold,
    output lsp_pkg::scan_state_t nxt
);

    logic [2:0]        w;
    logic [7:0]        mask;
    logic              left;
    logic              expand;
    logic [5:0]        cnt_inc;
    logic signed [4:0] np;
    logic signed [4:0] limit;

    always_comb
    begin
        nxt     = cur;
        pattern = '0;
        w       = {1'b0, tick.width} + 3'd1;
        mask    = ~(8'hFF << w);
        left    = cur.moving_left;
        expand  = cur.expanding;
        cnt_inc = {1'b0, cur.tick_cnt} + 6'd1;

        unique case (lsp_pkg::effect_t'(tick.effect))
            lsp_pkg::FX_SCANNER:
            begin
                pattern = mask << cur.pos;
            end
            lsp_pkg::FX_CENTER:
            begin
                pattern = lsp_pkg::center_bits(cur.pos, w);
            end
            lsp_pkg::FX_PAIR:
            begin
                pattern = lsp_pkg::pair_bits(cur.pos);
            end
            lsp_pkg::FX_CHASE_LEFT:
            begin
                pattern = mask << cur.pos;
                left    = 1'b1;
            end
            lsp_pkg::FX_CHASE_RIGHT:
            begin
                pattern = mask << cur.pos;
                left    = 1'b0;
            end
            lsp_pkg::FX_EXPAND:
            begin
                for (int i = 0; i < lsp_pkg::LED_COUNT; i++)
                begin
                    if (3'(i) < cur.pos)
                    begin
                        pattern = pattern | lsp_pkg::bit_at(5'(3 - i))
                                          | lsp_pkg::bit_at(5'(3 + i));
                    end
                end
                if (cur.pos >= 3'd4)
                begin
                    expand = 1'b0;
                end
                if (cur.pos == 3'd0)
                begin
                    expand = 1'b1;
                end
                left = ~expand;
            end
            lsp_pkg::FX_SPARKLE:
            begin
                nxt.rnd = {1'b0, cur.rnd[31:1]} ^ (cur.rnd[0] ? lsp_pkg::LFSR_TAPS : 32'd0);
                pattern = nxt.rnd[7:0];
            end
            lsp_pkg::FX_CYCLE:
            begin
                if (cnt_inc > 6'(lsp_pkg::CYCLE_TICKS))
                begin
                    nxt.sub      = (cur.sub == lsp_pkg::SUB_LAST) ? lsp_pkg::SUB_SCANNER2
                                                                  : cur.sub + 3'd1;
                    nxt.tick_cnt = '0;
                end
                else
                begin
                    nxt.tick_cnt = cnt_inc[4:0];
                end
                unique case (nxt.sub)
                    lsp_pkg::SUB_SCANNER2: pattern = 8'h03 << cur.pos;
                    lsp_pkg::SUB_CENTER3:  pattern = lsp_pkg::center_bits(cur.pos, 3'd3);
                    lsp_pkg::SUB_PAIR:     pattern = lsp_pkg::pair_bits(cur.pos);
                    lsp_pkg::SUB_SINGLE:   pattern = 8'h01 << cur.pos;
                    lsp_pkg::SUB_DOUBLE:   pattern = 8'h03 << cur.pos;
                    lsp_pkg::SUB_FILL:     pattern = 8'hFF << cur.pos;
                    default:               pattern = '0;
                endcase
            end
        endcase

        // Bounce between 0 and 8 - width
        np    = $signed({2'b00, cur.pos}) + (left ? -5'sd1 : 5'sd1);
        limit = 5'sd9 - $signed({2'b00, w});
        if (np >= limit)
        begin
            nxt.pos = 3'(4'd8 - {1'b0, w});
            left    = 1'b1;
        end
        else if (np < 5'sd0)
        begin
            nxt.pos = 3'd0;
            left    = 1'b0;
        end
        else
        begin
            nxt.pos = np[2:0];
        end

        nxt.moving_left = left;
        nxt.expanding   = expand;
    end

    assign hold = lsp_pkg::HOLD_BASE + lsp_pkg::HOLD_STEP * {6'b0, tick.speed};

endmodule

>>> src/lsp_state.sv
// Scan state registers: position, direction, flags, cycle counter, LFSR.
// Depends on lsp_pkg.
`timescale 1ns / 1ps

module lsp_state (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 seed_we,
    input  logic [31:0]          seed,
    input  logic                 update,
    input  lsp_pkg::scan_state_t state_in,
    output lsp_pkg::scan_state_t state
);

    lsp_pkg::scan_state_t state_reg;
    lsp_pkg::scan_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        if (update)
        begin
            state_next = state_in;
        end
        // seed write loads the generator directly
        if (seed_we)
        begin
            state_next.rnd = seed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pos         <= 3'd0;
            state_reg.moving_left <= 1'b0;
            state_reg.expanding   <= 1'b1;
            state_reg.sub         <= lsp_pkg::SUB_SCANNER2;
            state_reg.tick_cnt    <= 5'd0;
            state_reg.rnd         <= lsp_pkg::SEED_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule
